// ===== rtl/core/lphm_pkg.sv =====
package lphm_pkg;

	// default geometry
	localparam int LPHM_DEPTH      = 16;
	localparam int LPHM_KEY_BITS   = 32;
	localparam int LPHM_VALUE_BITS = 32;

	// field widths of the word on each channel
	localparam int LPHM_IN_W     = 32;
	localparam int LPHM_STATUS_W = 2;
	localparam int LPHM_SLOT_W   = 4;

	typedef enum logic [0:0] {
		FN_LOOKUP = 1'b0,
		FN_PUT    = 1'b1
	} func_t;

	typedef enum logic [LPHM_STATUS_W-1:0] {
		ST_FOUND    = 2'd0,
		ST_INSERTED = 2'd1,
		ST_UPDATED  = 2'd2,
		ST_MISS     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_MOD   = 4'b0010,
		S_PROBE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

endpackage

// ===== rtl/core/lphm_cell.sv =====
module lphm_cell import lphm_pkg::*; #(
	parameter int KEY_BITS   = LPHM_KEY_BITS,
	parameter int VALUE_BITS = LPHM_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  nxt_vld,
	input  logic [KEY_BITS-1:0]   nxt_key,
	input  logic [VALUE_BITS-1:0] nxt_val,
	input  logic                  wr_en,
	input  logic [KEY_BITS-1:0]   wr_key,
	input  logic [VALUE_BITS-1:0] wr_val,
	output logic                  slot_vld,
	output logic [KEY_BITS-1:0]   slot_key,
	output logic [VALUE_BITS-1:0] slot_val
);

	logic                  vld_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// occupancy flag is control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= wr_en ? 1'b1 : nxt_vld;
		end
	end

	// slot contents shift every cycle, replaced on a write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q <= wr_key;
			val_q <= wr_val;
		end else begin
			key_q <= nxt_key;
			val_q <= nxt_val;
		end
	end

	assign slot_vld = vld_q;
	assign slot_key = key_q;
	assign slot_val = val_q;

endmodule

// ===== rtl/core/lphm_mod.sv =====
module lphm_mod import lphm_pkg::*; #(
	parameter int DEPTH = LPHM_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [LPHM_IN_W-1:0]     hash,
	output logic                     done,
	output logic [$clog2(DEPTH)-1:0] rem
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam bit POW2  = (DEPTH & (DEPTH - 1)) == 0;

	logic             done_q;
	logic [IDX_W-1:0] r_q;

	generate
		if (POW2) begin : g_mask
			// remainder is the low hash bits
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= go;
				end
			end

			always_ff @(posedge clk) begin
				if (go) begin
					r_q <= hash[IDX_W-1:0];
				end
			end
		end else begin : g_recip
			localparam int R_W = IDX_W + 1;
			localparam logic [63:0]    TWO_32 = 64'd1 << 32;
			localparam logic [31:0]    RECIP  = 32'(TWO_32 / 64'(DEPTH));
			localparam logic [R_W-1:0] DEP_R  = R_W'(DEPTH);

			logic           v_s1;
			logic           v_s2;
			logic [63:0]    prod_s1;
			logic [R_W-1:0] h_s1;
			logic [R_W-1:0] r_s2;
			logic [R_W-1:0] q_lo;
			logic [R_W-1:0] r_est;
			logic [R_W-1:0] r_sub;

			// quotient from the truncated reciprocal is exact or one short,
			// so the first remainder lies below twice the depth and only its
			// low bits are needed; one compare and subtract finishes it
			always_comb begin
				q_lo  = prod_s1[32 +: R_W];
				r_est = h_s1 - q_lo * DEP_R;
				r_sub = r_s2 - DEP_R;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1   <= 1'b0;
					v_s2   <= 1'b0;
					done_q <= 1'b0;
				end else begin
					v_s1   <= go;
					v_s2   <= v_s1;
					done_q <= v_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (go) begin
					prod_s1 <= 64'(hash) * 64'(RECIP);
					h_s1    <= hash[R_W-1:0];
				end
				if (v_s1) begin
					r_s2 <= r_est;
				end
				if (v_s2) begin
					r_q <= (r_s2 >= DEP_R) ? r_sub[IDX_W-1:0] : r_s2[IDX_W-1:0];
				end
			end
		end
	endgenerate

	assign done = done_q;
	assign rem  = r_q;

endmodule

// ===== rtl/core/linear_probe_hash_map_top.sv =====
// sequence: start-slot reduction (low hash bits for a power-of-two depth, a reciprocal
//   pipeline otherwise), a wait until the start slot reaches the head cell, probing along
//   the ring, and the move into the output register
// throughput: one word at a time, set by the single compare point at the head of the slot
//   ring; the next word is taken the cycle after the result is registered, or later
//   while the output register is stalled
// reset: all slots empty, no word held, slot keys and values unset until first written
module linear_probe_hash_map_top import lphm_pkg::*; #(
	parameter int DEPTH      = LPHM_DEPTH,
	parameter int KEY_BITS   = LPHM_KEY_BITS,
	parameter int VALUE_BITS = LPHM_VALUE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic [LPHM_IN_W-1:0]     key,
	input  logic [LPHM_IN_W-1:0]     key_hash,
	input  logic [LPHM_IN_W-1:0]     value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [LPHM_STATUS_W-1:0] status,
	output logic [LPHM_IN_W-1:0]     read_value,
	output logic [LPHM_SLOT_W-1:0]   slot_index
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// the slots live in a ring of cells that rotates by one every cycle,
	// cell k takes the contents of cell k+1, and cell 0 is the head where
	// the pending word is compared; head_q names the slot sitting there
	logic                  c_vld [DEPTH];
	logic [KEY_BITS-1:0]   c_key [DEPTH];
	logic [VALUE_BITS-1:0] c_val [DEPTH];

	state_t                state_q;
	logic [IDX_W-1:0]      head_q;
	logic [IDX_W-1:0]      start_q;
	logic [IDX_W-1:0]      cnt_q;
	logic                  armed_q;

	// request held for the probe
	func_t                 func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// finished result waiting for the output register
	status_t               res_status_q;
	logic [VALUE_BITS-1:0] res_val_q;
	logic [IDX_W-1:0]      res_slot_q;

	// output register
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic [IDX_W-1:0]      out_slot_q;

	logic                  accept;
	logic                  mod_done;
	logic [IDX_W-1:0]      mod_rem;
	logic                  at_start;
	logic                  hit;
	logic                  full;
	logic                  tail_wr;
	logic                  out_free;
	logic [63:0]           key64;
	logic [63:0]           val64;
	logic [63:0]           rv64;
	logic [31:0]           slot32;
	status_t               hit_status;
	logic [VALUE_BITS-1:0] hit_val;

	assign key64  = {32'b0, key};
	assign val64  = {32'b0, value};

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// start slot is key_hash mod depth
	lphm_mod #(
		.DEPTH (DEPTH)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept),
		.hash   (key_hash),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// the ring; the head's outgoing slot re-enters at the tail, rewritten on a put
	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			localparam int NXT = (i + 1) % DEPTH;

			lphm_cell #(
				.KEY_BITS   (KEY_BITS),
				.VALUE_BITS (VALUE_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.nxt_vld  (c_vld[NXT]),
				.nxt_key  (c_key[NXT]),
				.nxt_val  (c_val[NXT]),
				.wr_en    ((i == DEPTH - 1) ? tail_wr : 1'b0),
				.wr_key   (key_q),
				.wr_val   (val_q),
				.slot_vld (c_vld[i]),
				.slot_key (c_key[i]),
				.slot_val (c_val[i])
			);
		end
	endgenerate

	// head compare: probing begins once the start slot comes round and then
	// follows the ring, stopping at an empty slot, a matching key or a full table
	always_comb begin
		at_start = armed_q || (head_q == start_q);
		hit      = !c_vld[0] || (c_key[0] == key_q);
		full     = (cnt_q == LAST_IDX) && !hit;
		tail_wr  = (state_q == S_PROBE) && at_start && hit && (func_q == FN_PUT);

		hit_val = '0;
		if (func_q == FN_PUT) begin
			hit_status = c_vld[0] ? ST_UPDATED : ST_INSERTED;
			hit_val    = val_q;
		end else if (c_vld[0]) begin
			hit_status = ST_FOUND;
			hit_val    = c_val[0];
		end else begin
			hit_status = ST_MISS;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

			// loaded when the result moves in, held until the word is taken
			out_valid_q <= ((state_q == S_DONE) && out_free) || (out_valid_q && !out_ready);

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_PROBE;
						armed_q <= 1'b0;
						cnt_q   <= '0;
					end
				end
				S_PROBE: begin
					if (at_start) begin
						if (hit || full) begin
							state_q <= S_DONE;
						end else begin
							armed_q <= 1'b1;
							cnt_q   <= cnt_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(func);
			key_q  <= key64[KEY_BITS-1:0];
			val_q  <= val64[VALUE_BITS-1:0];
		end
		if (mod_done && (state_q == S_MOD)) begin
			start_q <= mod_rem;
		end
		if ((state_q == S_PROBE) && at_start) begin
			if (hit) begin
				res_status_q <= hit_status;
				res_val_q    <= hit_val;
				res_slot_q   <= head_q;
			end else begin
				// no match at this slot; kept as the result only when every slot is taken
				res_status_q <= ST_MISS;
				res_val_q    <= (func_q == FN_PUT) ? val_q : '0;
				res_slot_q   <= '0;
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			out_status_q <= res_status_q;
			out_val_q    <= res_val_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign rv64   = 64'(out_val_q);
	assign slot32 = 32'(out_slot_q);

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign read_value = rv64[LPHM_IN_W-1:0];
	assign slot_index = slot32[LPHM_SLOT_W-1:0];

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lphm_pkg::*;

	localparam int DEPTH        = LPHM_DEPTH;
	localparam int RANDOM_WORDS = 700;
	localparam int KEY_POOL     = 24;
	// worst case per word: an idle gap at the sender, the time in the block and a
	// stall at the receiver; several times that over roughly 720 words
	localparam int LIMIT_CYCLES = 600000;

	// one request word and the reply word it should produce
	typedef struct packed {
		func_t       fn;
		logic [31:0] key;
		logic [31:0] hash;
		logic [31:0] val;
	} map_req_t;

	typedef struct packed {
		status_t                  st;
		logic [31:0]              rv;
		logic [LPHM_SLOT_W-1:0]   slot;
	} map_reply_t;

	logic                     clk        = 1'b0;
	logic                     arst_n;
	logic                     in_valid   = 1'b0;
	logic                     in_ready;
	logic                     func       = 1'b0;
	logic [LPHM_IN_W-1:0]     key        = '0;
	logic [LPHM_IN_W-1:0]     key_hash   = '0;
	logic [LPHM_IN_W-1:0]     value      = '0;
	logic                     out_valid;
	logic                     out_ready  = 1'b0;
	logic [LPHM_STATUS_W-1:0] status;
	logic [LPHM_IN_W-1:0]     read_value;
	logic [LPHM_SLOT_W-1:0]   slot_index;

	linear_probe_hash_map_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.key        (key),
		.key_hash   (key_hash),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_value (read_value),
		.slot_index (slot_index)
	);

	// shadow copy of the table, updated as each request word is taken
	logic        tbl_used [DEPTH];
	logic [31:0] tbl_key  [DEPTH];
	logic [31:0] tbl_val  [DEPTH];
	logic [4:0]  tbl_count = '0;

	map_req_t   pending_reqs[$];
	map_reply_t replies_due[$];
	map_req_t   cur_req;

	int  words_total = 0;
	int  words_taken = 0;
	int  errors      = 0;
	int  n_found = 0, n_miss = 0, n_insert = 0, n_update = 0, n_full_put = 0;
	int  send_gap = 0;
	int  ready_hold = 0;
	bit  tx_steady = 1'b0;
	bit  rx_steady = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	// walk the table from the hashed slot, stop at an empty slot or a key
	// match, then apply the lookup or put to the shadow table
	function automatic map_reply_t map_apply(map_req_t r);
		map_reply_t rep;
		int         pos;
		int         hit;
		int         n;
		bit         stopped;
		stopped = 1'b0;
		hit     = 0;
		pos     = r.hash % DEPTH;
		for (n = 0; n < DEPTH; n++) begin
			if (!stopped && (!tbl_used[pos] || tbl_key[pos] == r.key)) begin
				stopped = 1'b1;
				hit     = pos;
			end
			pos = (pos + 1) % DEPTH;
		end
		rep.slot = hit[LPHM_SLOT_W-1:0];
		if (r.fn == FN_LOOKUP) begin
			if (stopped && tbl_used[hit]) begin
				rep.st = ST_FOUND;
				rep.rv = tbl_val[hit];
			end else begin
				rep.st = ST_MISS;
				rep.rv = '0;
			end
		end else begin
			rep.rv = r.val;
			if (!stopped) begin
				// every slot taken by another key: nothing changes
				rep.st = ST_MISS;
			end else if (tbl_used[hit]) begin
				tbl_val[hit] = r.val;
				rep.st = ST_UPDATED;
			end else begin
				tbl_used[hit] = 1'b1;
				tbl_key[hit]  = r.key;
				tbl_val[hit]  = r.val;
				tbl_count     = tbl_count + 5'd1;
				rep.st = ST_INSERTED;
			end
		end
		return rep;
	endfunction

	// mostly short gaps, now and then a long one; none at all while steady
	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic push_req(func_t fn, logic [31:0] k, logic [31:0] h, logic [31:0] v);
		map_req_t r;
		r.fn   = fn;
		r.key  = k;
		r.hash = h;
		r.val  = v;
		pending_reqs.push_back(r);
		words_total++;
	endtask

	// request driver: a word stays on the port until it is taken, then the
	// shadow table works out its reply
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func     <= FN_LOOKUP;
			key      <= '0;
			key_hash <= '0;
			value    <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				map_reply_t rep;
				rep = map_apply(cur_req);
				replies_due.push_back(rep);
				words_taken++;
				case (rep.st)
					ST_FOUND:    n_found++;
					ST_INSERTED: n_insert++;
					ST_UPDATED:  n_update++;
					ST_MISS: begin
						if (cur_req.fn == FN_PUT)
							n_full_put++;
						else
							n_miss++;
					end
				endcase
				if ($urandom_range(0, 49) == 0)
					tx_steady = !tx_steady;
				send_gap = pick_gap(tx_steady);
			end
			// the port is free once nothing is held or the held word was taken
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (pending_reqs.size() > 0) begin
					cur_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					func     <= cur_req.fn;
					key      <= cur_req.key;
					key_hash <= cur_req.hash;
					value    <= cur_req.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// reply monitor: check each reply word against the oldest prediction,
	// then decide back-pressure for the next cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: reply word with none outstanding: status %0d value %h slot %0d",
						$time, status, read_value, slot_index);
					errors++;
				end else begin
					map_reply_t want;
					want = replies_due.pop_front();
					if (status !== want.st) begin
						$display("%0t: status expected %0d got %0d", $time, want.st, status);
						errors++;
					end
					if (read_value !== want.rv) begin
						$display("%0t: read_value expected %h got %h", $time, want.rv,
							read_value);
						errors++;
					end
					if (slot_index !== want.slot) begin
						$display("%0t: slot_index expected %0d got %0d", $time, want.slot,
							slot_index);
						errors++;
					end
				end
				if ($urandom_range(0, 49) == 0)
					rx_steady = !rx_steady;
				ready_hold = pick_gap(rx_steady);
			end else if (out_ready && !rx_steady && $urandom_range(0, 31) == 0) begin
				// occasional stall with no word waiting
				ready_hold = $urandom_range(1, 6);
			end
			if (ready_hold > 0) begin
				out_ready <= 1'b0;
				ready_hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("%0t: timed out with %0d of %0d words taken, %0d replies outstanding",
			$time, words_taken, words_total, replies_due.size());
		$display("[linear_probe_hash_map_top] ERROR");
		$finish;
	end

	initial begin
		logic [31:0] pool_key  [KEY_POOL];
		logic [31:0] pool_hash [KEY_POOL];
		logic [31:0] v;
		logic [31:0] h;
		func_t       fn;
		int          i;
		int          live;
		int          pick;
		int          roll;

		// a real falling edge on the reset, once every process is waiting
		arst_n <= 1'b0;

		for (i = 0; i < DEPTH; i++)
			tbl_used[i] = 1'b0;

		// directed: empty-slot miss, field extremes, wrap from the last slot,
		// overwrite of an existing key, hash with high bits set
		push_req(FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		push_req(FN_PUT,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		push_req(FN_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(FN_PUT,    32'h1234_5678, 32'h0000_000F, 32'h5A5A_5A5A);
		push_req(FN_LOOKUP, 32'h1234_5678, 32'h0000_000F, 32'h0000_0000);
		push_req(FN_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
		push_req(FN_LOOKUP, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
		push_req(FN_LOOKUP, 32'hDEAD_BEEF, 32'h0000_000F, 32'h0000_0000);
		push_req(FN_LOOKUP, 32'h0000_0000, 32'hFFFF_FFF0, 32'h0000_0000);
		push_req(FN_PUT,    32'h8000_0000, 32'h8000_0003, 32'h7FFF_FFFF);
		push_req(FN_LOOKUP, 32'h8000_0000, 32'h0000_0003, 32'h0000_0000);
		push_req(FN_PUT,    32'h0000_0000, 32'h0000_0000, 32'h8000_0001);
		push_req(FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

		// a pool of keys, each with its own hash; the live part of the pool
		// grows so the table fills gradually and ends up full
		for (i = 0; i < KEY_POOL; i++) begin
			pool_key[i]  = $urandom;
			pool_hash[i] = $urandom;
		end

		for (i = 0; i < RANDOM_WORDS; i++) begin
			live = 3 + i / 30;
			if (live > KEY_POOL)
				live = KEY_POOL;
			pick = $urandom_range(0, live - 1);
			roll = $urandom_range(0, 99);
			case ($urandom_range(0, 19))
				0:       v = '0;
				1:       v = '1;
				default: v = $urandom;
			endcase
			if (roll < 10) begin
				// noise: unknown keys, mostly lookups; puts only late so the
				// pool still has room to fill the table slowly
				fn = (i > 400 && $urandom_range(0, 3) == 0) ? FN_PUT : FN_LOOKUP;
				push_req(fn, $urandom, $urandom, v);
			end else begin
				fn = (roll < 55) ? FN_PUT : FN_LOOKUP;
				h  = pool_hash[pick];
				// a known key with a stray hash; put this way only late on,
				// since it may place the same key a second time
				if ($urandom_range(0, 19) == 0 && (fn == FN_LOOKUP || i > 450))
					h = $urandom;
				push_req(fn, pool_key[pick], h, v);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// sample on the falling edge so every update of the rising edge has landed
		do
			@(negedge clk);
		while (!(words_taken == words_total && replies_due.size() == 0));

		// room for any stray reply word to show up
		repeat (120) @(negedge clk);

		$display("run covered %0d words: %0d lookup hits, %0d lookup misses, %0d inserts,",
			words_taken, n_found, n_miss, n_insert);
		$display("  %0d updates, %0d puts refused by a full table; %0d entries at the end",
			n_update, n_full_put, tbl_count);
		if (errors == 0)
			$display("[linear_probe_hash_map_top] OK");
		else
			$display("[linear_probe_hash_map_top] ERROR");
		$finish;
	end

endmodule
